>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the formatter.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define IFF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define IFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/iff_pkg.sv
// Package for the integer field formatter: sizes, state type and digit helpers.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package iff_pkg;

    localparam int MAX_OUT_CHARS = 64;
    localparam int VALUE_BITS    = 64;

    // Field widths of the channels
    localparam int MAG_W  = 64;
    localparam int MODE_W = 2;
    localparam int FW_W   = 7;
    localparam int CHAR_W = 7;

    // Digit storage: decimal needs the most digits
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NUM_DIGITS = DEC_DIGITS;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int PAD_W      = $clog2(MAX_OUT_CHARS + 1);
    localparam int CMP_W      = ((PAD_W > FW_W) ? PAD_W : FW_W) + 1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_DEC       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEX_LOWER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX_UPPER = 2'd2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_PREP,
        ST_PAD_PRE,
        ST_SIGN,
        ST_DIGIT,
        ST_PAD_POST
    } state_t;

    // Map one digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] letter_base;
        letter_base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10)
            return CH_ZERO + CHAR_W'(d);
        else
            return letter_base + CHAR_W'(d - 4'd10);
    endfunction

endpackage

>>> rtl/iff_if.sv
// Valid/ready channels of the integer field formatter: input item and output character.
// Depends on iff_pkg for the field widths.
`timescale 1ns / 1ps

interface iff_in_if;
    logic                            valid;
    logic                            ready;
    logic [iff_pkg::MAG_W-1:0]       magnitude;
    logic                            is_negative;
    logic [iff_pkg::MODE_W-1:0]      mode;
    logic [iff_pkg::FW_W-1:0]        field_width;
    logic                            left_align;
    logic                            zero_fill;

    modport source (output valid, magnitude, is_negative, mode, field_width,
                    left_align, zero_fill, input ready);
    modport sink   (input valid, magnitude, is_negative, mode, field_width,
                    left_align, zero_fill, output ready);
endinterface

interface iff_out_if;
    logic                            valid;
    logic                            ready;
    logic [iff_pkg::CHAR_W-1:0]      out_char;
    logic                            last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink   (input valid, out_char, last_char, output ready);
endinterface

>>> rtl/integer_field_formatter.sv
// Integer field formatter top level: sequencer, shift-add-3 converter, serializer.
// Depends on iff_pkg and the channel interfaces in iff_if.sv.
`timescale 1ns / 1ps

// Takes one item (magnitude, sign, mode, width, flags) and emits the formatted
// ASCII field one character per output item, the final one flagged by last_char.
// The block takes one item at a time; fmt_in.ready is high only between fields,
// and a new item may enter while the last character still waits at the output.
// A decimal item first shifts all VALUE_BITS (64) magnitude bits through the
// shift-add-3 binary-to-BCD unit; hex items skip it. A leading-zero scan then
// suppresses up to 19 decimal or 15 hex digits, keeping at least one, a prep
// state sizes the padding, and each character is emitted when the output is
// free. The next item can be accepted once the last character is registered.
module integer_field_formatter (
    input  logic       clk,
    input  logic       rst_n,
    iff_in_if.sink     fmt_in,
    iff_out_if.source  fmt_out
);

    localparam int DW = iff_pkg::NUM_DIGITS * 4;

    iff_pkg::state_t state_reg, state_next;

    logic [iff_pkg::VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [DW-1:0]                   digits_reg, digits_next;
    logic [iff_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [iff_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [iff_pkg::PAD_W-1:0]       pad_reg, pad_next;
    logic [iff_pkg::PAD_W-1:0]       width_reg, width_next;
    logic                            neg_reg, neg_next;
    logic                            upper_reg, upper_next;
    logic                            left_reg, left_next;
    logic                            zero_reg, zero_next;

    logic                            out_valid_reg, out_valid_next;
    logic [iff_pkg::CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;

    logic                            in_fire;
    logic                            out_free;
    logic [3:0]                      cur_digit;
    logic [DW-1:0]                   adjusted;
    logic [iff_pkg::CMP_W-1:0]       total;
    logic [iff_pkg::CMP_W-1:0]       width_ext;
    logic [iff_pkg::CMP_W-1:0]       fw_ext;
    logic [iff_pkg::CMP_W-1:0]       max_ext;
    logic [iff_pkg::PAD_W-1:0]       pad_calc;
    logic                            hex_in;

    assign fmt_in.ready  = (state_reg == iff_pkg::ST_IDLE);
    assign in_fire       = fmt_in.valid && fmt_in.ready;
    assign out_free      = !out_valid_reg || fmt_out.ready;
    assign hex_in        = (fmt_in.mode != iff_pkg::MODE_DEC);

    assign fmt_out.valid     = out_valid_reg;
    assign fmt_out.out_char  = out_char_reg;
    assign fmt_out.last_char = out_last_reg;

    // Select the digit under the scan and emit index
    assign cur_digit = digits_reg[idx_reg * 4 +: 4];

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < iff_pkg::NUM_DIGITS; d++)
        begin
            if (digits_reg[d * 4 +: 4] >= 4'd5)
                adjusted[d * 4 +: 4] = digits_reg[d * 4 +: 4] + 4'd3;
            else
                adjusted[d * 4 +: 4] = digits_reg[d * 4 +: 4];
        end
    end

    // Saturate the requested width and size the padding
    assign fw_ext    = iff_pkg::CMP_W'(fmt_in.field_width);
    assign max_ext   = iff_pkg::CMP_W'(iff_pkg::MAX_OUT_CHARS);
    assign width_ext = iff_pkg::CMP_W'(width_reg);
    assign total     = iff_pkg::CMP_W'(idx_reg) + iff_pkg::CMP_W'(1)
                     + iff_pkg::CMP_W'(neg_reg);
    assign pad_calc  = (width_ext > total) ? iff_pkg::PAD_W'(width_ext - total)
                                           : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iff_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = hex_in ? iff_pkg::ST_SCAN : iff_pkg::ST_CONV;
            end
            iff_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == '0)
                    state_next = iff_pkg::ST_SCAN;
            end
            iff_pkg::ST_SCAN:
            begin
                if (idx_reg == '0 || cur_digit != 4'd0)
                    state_next = iff_pkg::ST_PREP;
            end
            iff_pkg::ST_PREP:
            begin
                priority if (!left_reg && !zero_reg && pad_calc != '0)
                    state_next = iff_pkg::ST_PAD_PRE;
                else if (neg_reg)
                    state_next = iff_pkg::ST_SIGN;
                else if (!left_reg && zero_reg && pad_calc != '0)
                    state_next = iff_pkg::ST_PAD_PRE;
                else
                    state_next = iff_pkg::ST_DIGIT;
            end
            iff_pkg::ST_PAD_PRE:
            begin
                if (out_free && pad_reg == iff_pkg::PAD_W'(1))
                    state_next = (!zero_reg && neg_reg) ? iff_pkg::ST_SIGN
                                                        : iff_pkg::ST_DIGIT;
            end
            iff_pkg::ST_SIGN:
            begin
                if (out_free)
                    state_next = (!left_reg && zero_reg && pad_reg != '0)
                               ? iff_pkg::ST_PAD_PRE : iff_pkg::ST_DIGIT;
            end
            iff_pkg::ST_DIGIT:
            begin
                if (out_free && idx_reg == '0)
                    state_next = (left_reg && pad_reg != '0) ? iff_pkg::ST_PAD_POST
                                                             : iff_pkg::ST_IDLE;
            end
            iff_pkg::ST_PAD_POST:
            begin
                if (out_free && pad_reg == iff_pkg::PAD_W'(1))
                    state_next = iff_pkg::ST_IDLE;
            end
            default:
                state_next = iff_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        bin_next       = bin_reg;
        digits_next    = digits_reg;
        bit_cnt_next   = bit_cnt_reg;
        idx_next       = idx_reg;
        pad_next       = pad_reg;
        width_next     = width_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !fmt_out.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            iff_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    bin_next     = fmt_in.magnitude[iff_pkg::VALUE_BITS-1:0];
                    neg_next     = fmt_in.is_negative;
                    upper_next   = fmt_in.mode[1];
                    left_next    = fmt_in.left_align;
                    zero_next    = fmt_in.zero_fill;
                    width_next   = (fw_ext > max_ext) ? iff_pkg::PAD_W'(max_ext)
                                                      : iff_pkg::PAD_W'(fw_ext);
                    bit_cnt_next = iff_pkg::BIT_CNT_W'(iff_pkg::VALUE_BITS - 1);
                    digits_next  = '0;
                    if (hex_in)
                    begin
                        digits_next[iff_pkg::VALUE_BITS-1:0] =
                            fmt_in.magnitude[iff_pkg::VALUE_BITS-1:0];
                        idx_next = iff_pkg::IDX_W'(iff_pkg::HEX_DIGITS - 1);
                    end
                    else
                    begin
                        idx_next = iff_pkg::IDX_W'(iff_pkg::DEC_DIGITS - 1);
                    end
                end
            end
            iff_pkg::ST_CONV:
            begin
                // Shift one magnitude bit into the adjusted BCD register
                digits_next  = {adjusted[DW-2:0], bin_reg[iff_pkg::VALUE_BITS-1]};
                bin_next     = {bin_reg[iff_pkg::VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - iff_pkg::BIT_CNT_W'(1);
            end
            iff_pkg::ST_SCAN:
            begin
                // Drop leading zeros, keeping at least one digit
                if (idx_reg != '0 && cur_digit == 4'd0)
                    idx_next = idx_reg - iff_pkg::IDX_W'(1);
            end
            iff_pkg::ST_PREP:
            begin
                pad_next = pad_calc;
            end
            iff_pkg::ST_PAD_PRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = zero_reg ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
                    out_last_next  = 1'b0;
                    pad_next       = pad_reg - iff_pkg::PAD_W'(1);
                end
            end
            iff_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iff_pkg::CH_MINUS;
                    out_last_next  = 1'b0;
                end
            end
            iff_pkg::ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iff_pkg::digit_char(cur_digit, upper_reg);
                    out_last_next  = (idx_reg == '0) && !(left_reg && pad_reg != '0);
                    if (idx_reg != '0)
                        idx_next = idx_reg - iff_pkg::IDX_W'(1);
                end
            end
            iff_pkg::ST_PAD_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = iff_pkg::CH_SPACE;
                    out_last_next  = (pad_reg == iff_pkg::PAD_W'(1));
                    pad_next       = pad_reg - iff_pkg::PAD_W'(1);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iff_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        digits_reg   <= digits_next;
        bit_cnt_reg  <= bit_cnt_next;
        idx_reg      <= idx_next;
        pad_reg      <= pad_next;
        width_reg    <= width_next;
        neg_reg      <= neg_next;
        upper_reg    <= upper_next;
        left_reg     <= left_next;
        zero_reg     <= zero_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> rtl/iff_checker.sv
// Port-level checker for the integer field formatter, bound to the top level.
// Depends on iff_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iff_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [iff_pkg::CHAR_W-1:0]  out_char,
    input logic                        last_char
);

    logic printable;

    // Characters the formatter can produce: space, minus, digits, hex letters
    assign printable = (out_char == iff_pkg::CH_SPACE) || (out_char == iff_pkg::CH_MINUS)
                    || (out_char >= 7'h30 && out_char <= 7'h39)
                    || (out_char >= 7'h41 && out_char <= 7'h46)
                    || (out_char >= 7'h61 && out_char <= 7'h66);

    // A stalled character stays offered
    `IFF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // An accepted item blocks the input for at least the next cycle
    `IFF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // No new item while the field is still being emitted
    `IFF_ASSERT_SAME(a_busy_mid_field, out_valid && !last_char, !in_ready)

    // Only field characters appear on the output
    `IFF_ASSERT_SAME(a_char_set, out_valid, printable)

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fmt_in.valid),
    .in_ready  (fmt_in.ready),
    .out_valid (fmt_out.valid),
    .out_ready (fmt_out.ready),
    .out_char  (fmt_out.out_char),
    .last_char (fmt_out.last_char)
);

>>> verif/tb.sv
// Self-checking testbench for integer_field_formatter: drives format requests and checks
// every output character. Depends on iff_pkg and the channel interfaces in rtl/iff_if.sv.
`timescale 1ns / 1ps

module tb;

    // Mode code outside the documented set; the block treats it as uppercase hex
    localparam logic [iff_pkg::MODE_W-1:0] MODE_HEX_ALT = 2'd3;
    localparam int TAIL_CYCLES = 200;

    typedef struct {
        logic [iff_pkg::MAG_W-1:0]  magnitude;
        logic                       is_negative;
        logic [iff_pkg::MODE_W-1:0] mode;
        logic [iff_pkg::FW_W-1:0]   field_width;
        logic                       left_align;
        logic                       zero_fill;
    } fmt_req_t;

    typedef struct {
        logic [iff_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } fmt_char_t;

    logic clk;
    logic rst_n;

    iff_in_if  in_ch ();
    iff_out_if out_ch ();

    integer_field_formatter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt_in  (in_ch),
        .fmt_out (out_ch)
    );

    fmt_req_t  fields_to_send[$];
    fmt_char_t field_chars_q[$];

    logic in_fire;
    int   n_total;
    int   n_fields;
    int   n_dec;
    int   n_neg;
    int   n_chars;
    int   n_errors;
    int   src_idle_pct;
    int   snk_idle_pct;

    // Build the expected character string of one field and queue it
    function automatic void format_field(input fmt_req_t r);
        string                      lower_set;
        string                      upper_set;
        logic [iff_pkg::CHAR_W-1:0] digits[$];
        logic [iff_pkg::CHAR_W-1:0] text[$];
        logic [63:0]                v;
        logic [63:0]                base;
        logic [3:0]                 d;
        int                         width;
        int                         pad;
        fmt_char_t                  c;
        lower_set = "0123456789abcdef";
        upper_set = "0123456789ABCDEF";
        v     = r.magnitude;
        base  = (r.mode != iff_pkg::MODE_DEC) ? 64'd16 : 64'd10;
        width = (int'(r.field_width) > iff_pkg::MAX_OUT_CHARS) ? iff_pkg::MAX_OUT_CHARS
                                                               : int'(r.field_width);

        // Extract digits, most significant ending up first
        do
        begin
            d = 4'(v % base);
            digits.push_front(iff_pkg::CHAR_W'(r.mode[1] ? upper_set[d] : lower_set[d]));
            v = v / base;
        end
        while (v != 0);

        pad = width - (digits.size() + (r.is_negative ? 1 : 0));
        if (pad < 0)
            pad = 0;

        // Lay out: leading spaces, sign, zeros, digits, trailing spaces
        if (!r.left_align && !r.zero_fill)
            repeat (pad) text.push_back(iff_pkg::CH_SPACE);
        if (r.is_negative)
            text.push_back(iff_pkg::CH_MINUS);
        if (!r.left_align && r.zero_fill)
            repeat (pad) text.push_back(iff_pkg::CH_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
        if (r.left_align)
            repeat (pad) text.push_back(iff_pkg::CH_SPACE);

        foreach (text[i])
        begin
            c.ch   = text[i];
            c.last = (i == text.size() - 1);
            field_chars_q.push_back(c);
        end
    endfunction

    task automatic add_field(input logic [iff_pkg::MAG_W-1:0] mag, input logic neg,
                             input logic [iff_pkg::MODE_W-1:0] mode, input int fw,
                             input logic left, input logic zero);
        fmt_req_t r;
        r.magnitude   = mag;
        r.is_negative = neg;
        r.mode        = mode;
        r.field_width = iff_pkg::FW_W'(fw);
        r.left_align  = left;
        r.zero_fill   = zero;
        fields_to_send.push_back(r);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Sender: hold an item until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!(in_ch.valid && !in_fire))
        begin
            if (in_ch.valid && in_fire)
                void'(fields_to_send.pop_front());
            if (fields_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                in_ch.valid       <= 1'b1;
                in_ch.magnitude   <= fields_to_send[0].magnitude;
                in_ch.is_negative <= fields_to_send[0].is_negative;
                in_ch.mode        <= fields_to_send[0].mode;
                in_ch.field_width <= fields_to_send[0].field_width;
                in_ch.left_align  <= fields_to_send[0].left_align;
                in_ch.zero_fill   <= fields_to_send[0].zero_fill;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: predict on each accepted field, check each accepted character
    always @(posedge clk)
    begin
        fmt_req_t  r;
        fmt_char_t e;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                r.magnitude   = in_ch.magnitude;
                r.is_negative = in_ch.is_negative;
                r.mode        = in_ch.mode;
                r.field_width = in_ch.field_width;
                r.left_align  = in_ch.left_align;
                r.zero_fill   = in_ch.zero_fill;
                format_field(r);
                n_fields++;
                if (r.mode == iff_pkg::MODE_DEC)
                    n_dec++;
                if (r.is_negative)
                    n_neg++;
                // Step through the idling phases as fields are taken
                if (n_fields < n_total / 3)
                begin
                    src_idle_pct <= 29;
                    snk_idle_pct <= 67;
                end
                else if (n_fields < (2 * n_total) / 3)
                begin
                    src_idle_pct <= 67;
                    snk_idle_pct <= 29;
                end
                else
                begin
                    src_idle_pct <= 0;
                    snk_idle_pct <= 0;
                end
            end

            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                n_chars++;
                if (field_chars_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("[%0t] unexpected character 0x%h last=%b",
                                 $realtime, out_ch.out_char, out_ch.last_char);
                end
                else
                begin
                    e = field_chars_q.pop_front();
                    if (out_ch.out_char !== e.ch || out_ch.last_char !== e.last)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("[%0t] char mismatch: expected 0x%h last=%b, %s",
                                     $realtime, e.ch, e.last,
                                     $sformatf("got 0x%h last=%b", out_ch.out_char,
                                               out_ch.last_char));
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int sh;
        int fw;
        logic [iff_pkg::MAG_W-1:0] mag;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.magnitude   = '0;
        in_ch.is_negative = 1'b0;
        in_ch.mode        = iff_pkg::MODE_DEC;
        in_ch.field_width = '0;
        in_ch.left_align  = 1'b0;
        in_ch.zero_fill   = 1'b0;
        out_ch.ready      = 1'b0;
        in_fire           = 1'b0;
        n_fields          = 0;
        n_dec             = 0;
        n_neg             = 0;
        n_chars           = 0;
        n_errors          = 0;
        src_idle_pct      = 29;
        snk_idle_pct      = 67;

        // Directed: extremes, every mode, sign and padding layouts
        add_field(64'd0, 1'b0, iff_pkg::MODE_DEC, 0, 1'b0, 1'b0);
        add_field('1, 1'b0, iff_pkg::MODE_DEC, 0, 1'b0, 1'b0);
        add_field('1, 1'b1, iff_pkg::MODE_DEC, 64, 1'b0, 1'b1);
        add_field('1, 1'b0, iff_pkg::MODE_HEX_LOWER, 0, 1'b0, 1'b0);
        add_field('1, 1'b0, iff_pkg::MODE_HEX_UPPER, 20, 1'b0, 1'b1);
        add_field(64'hDEAD_BEEF, 1'b0, MODE_HEX_ALT, 12, 1'b0, 1'b0);
        add_field(64'hDEAD_BEEF, 1'b1, iff_pkg::MODE_HEX_LOWER, 12, 1'b1, 1'b0);
        add_field(64'd0, 1'b1, iff_pkg::MODE_DEC, 0, 1'b0, 1'b0);
        add_field(64'd0, 1'b1, iff_pkg::MODE_HEX_UPPER, 5, 1'b0, 1'b1);
        add_field(64'd42, 1'b0, iff_pkg::MODE_DEC, 127, 1'b0, 1'b0);
        add_field(64'd42, 1'b1, iff_pkg::MODE_DEC, 127, 1'b1, 1'b1);
        add_field(64'd42, 1'b1, iff_pkg::MODE_DEC, 65, 1'b0, 1'b1);
        add_field(64'd42, 1'b1, iff_pkg::MODE_DEC, 64, 1'b0, 1'b0);
        add_field(64'd1234567, 1'b0, iff_pkg::MODE_DEC, 3, 1'b0, 1'b1);
        add_field(64'd1234567, 1'b1, iff_pkg::MODE_DEC, 8, 1'b0, 1'b0);
        add_field(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, iff_pkg::MODE_HEX_LOWER, 17, 1'b1, 1'b1);
        add_field(64'h5555_5555_5555_5555, 1'b1, iff_pkg::MODE_DEC, 30, 1'b0, 1'b1);
        add_field(64'h8000_0000_0000_0000, 1'b0, iff_pkg::MODE_HEX_UPPER, 1, 1'b0, 1'b0);
        add_field(64'd9, 1'b0, iff_pkg::MODE_DEC, 1, 1'b1, 1'b0);
        add_field(64'd10, 1'b0, iff_pkg::MODE_HEX_LOWER, 2, 1'b0, 1'b1);

        // Random: mostly short widths, some saturating ones
        repeat (100)
        begin
            if ($urandom_range(0, 9) == 0)
                mag = iff_pkg::MAG_W'($urandom_range(0, 15));
            else
            begin
                sh  = $urandom_range(0, 63);
                mag = {$urandom, $urandom} >> sh;
            end
            fw = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 127) : $urandom_range(0, 24);
            add_field(mag, 1'($urandom), iff_pkg::MODE_W'($urandom_range(0, 3)), fw,
                      1'($urandom), 1'($urandom));
        end
        n_total = fields_to_send.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all fields sent, all characters back, then a quiet tail
        wait (fields_to_send.size() == 0 && in_ch.valid == 1'b0);
        while (field_chars_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d fields (%0d decimal, %0d hex, %0d negative), %0d characters",
                 n_fields, n_dec, n_fields - n_dec, n_neg, n_chars);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0 && field_chars_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
